[sv/givens_rotation_macros.svh]
// Assertion helpers shared by the rotation RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef GIVENS_ROTATION_MACROS_SVH
`define GIVENS_ROTATION_MACROS_SVH

// same-cycle implication
`define GR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/gr_pkg.sv]
// ----------------------------------------------------------------------------
// gr_pkg
// Shared constants of the Givens rotation unit.
// ----------------------------------------------------------------------------
package gr_pkg;
	localparam int GR_DATA_WIDTH = 16;
endpackage

[sv/gr_divider.sv]
// ----------------------------------------------------------------------------
// gr_divider
// Pipelined restoring divider: quo = floor(num * 2^(2W) / den), for num <= den.
// One quotient bit per stage, side bits travel alongside.
// ----------------------------------------------------------------------------
module gr_divider #(
	parameter int W      = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*W-1:0]    num,
	input  logic [2*W-1:0]    den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [2*W:0]      quo,
	output logic [SIDE_W-1:0] side_out
);
	localparam int STAGES = 2 * W + 1;

	logic [STAGES:0] valid_s;
	logic [2*W-1:0]  rem_s  [0:STAGES];
	logic [2*W-1:0]  den_s  [0:STAGES];
	logic [2*W:0]    quo_s  [0:STAGES];
	logic [SIDE_W-1:0] side_s [0:STAGES];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = num;
	assign den_s[0]   = den;
	assign quo_s[0]   = '0;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [2*W:0] cand;
		logic [2*W:0] diff;
		logic         take;

		if (k == 0) begin : g_first
			assign cand = {1'b0, rem_s[k]};
		end else begin : g_next
			assign cand = {rem_s[k], 1'b0};
		end

		assign take = cand >= {1'b0, den_s[k]};
		assign diff = cand - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? diff[2*W-1:0] : cand[2*W-1:0];
			den_s[k+1]  <= den_s[k];
			quo_s[k+1]  <= {quo_s[k][2*W-1:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[STAGES];
	assign quo       = quo_s[STAGES];
	assign side_out  = side_s[STAGES];
endmodule

[sv/gr_isqrt.sv]
// ----------------------------------------------------------------------------
// gr_isqrt
// Pipelined digit-by-digit integer square root, floor(sqrt(rad)).
// One root bit per stage, side bits travel alongside.
// ----------------------------------------------------------------------------
module gr_isqrt #(
	parameter int IN_W   = 34,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     rad,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);
	localparam int OUT_W = IN_W / 2;

	logic [OUT_W:0]      valid_s;
	logic [IN_W-1:0]     rad_s  [0:OUT_W];
	logic [OUT_W:0]      rem_s  [0:OUT_W];
	logic [OUT_W-1:0]    root_s [0:OUT_W];
	logic [SIDE_W-1:0]   side_s [0:OUT_W];

	assign valid_s[0] = in_valid;
	assign rad_s[0]   = rad;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [OUT_W+2:0] cur;
		logic [OUT_W+2:0] trial;
		logic [OUT_W+2:0] diff;
		logic             take;

		// bring down the next two radicand bits
		assign cur   = {rem_s[k], rad_s[k][IN_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign take  = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= rad_s[k] << 2;
			rem_s[k+1]  <= take ? diff[OUT_W:0] : cur[OUT_W:0];
			root_s[k+1] <= {root_s[k][OUT_W-2:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[OUT_W];
	assign root      = root_s[OUT_W];
	assign side_out  = side_s[OUT_W];
endmodule

[sv/givens_rotation.sv]
// Path from accepted start to done: magnitude, square and sum registers, divider, root, output register.
// Throughput: one word per clock; busy is always low and done cannot be held off.
// Latency is set by the divider (2*DATA_WIDTH+1 stages) and the root (DATA_WIDTH+1).
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
// givens_rotation
// Returns c, s and r of the plane rotation that maps (a, b) to (r, 0).
// ----------------------------------------------------------------------------
`include "givens_rotation_macros.svh"

module givens_rotation
	import gr_pkg::*;
#(
	parameter int DATA_WIDTH = GR_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] a_in,
	input  logic signed [DATA_WIDTH-1:0] b_in,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] cos_out,
	output logic signed [DATA_WIDTH-1:0] sin_out,
	output logic        [DATA_WIDTH-1:0] radius_out
);
	localparam int W = DATA_WIDTH;

	function automatic logic [W-1:0] to_field(input logic [W:0] t, input logic neg);
		logic [W+1:0] sum;
		logic [W:0]   q;
		logic [W:0]   nq;
		sum = {1'b0, t} + {{(W+1){1'b0}}, 1'b1};
		q   = sum[W+1:1];
		nq  = ~q + {{W{1'b0}}, 1'b1};
		if (neg) begin
			return nq[W-1:0];
		end else if (q > {2'b00, {(W-1){1'b1}}}) begin
			return {1'b0, {(W-1){1'b1}}};
		end else begin
			return q[W-1:0];
		end
	endfunction

	// stage 1: magnitudes
	logic         valid_s1;
	logic [W-1:0] ma_s1, mb_s1;
	logic         na_s1, nb_s1;
	// stage 2: squares
	logic           valid_s2;
	logic [2*W-1:0] pa_s2, pb_s2;
	logic           na_s2, nb_s2;
	// stage 3: sum of squares
	logic           valid_s3;
	logic [2*W-1:0] pa_s3, pb_s3, n_s3;
	logic           na_s3, nb_s3;

	logic [2*W-1:0] sq_a, sq_b;

	assign busy = 1'b0;
	assign sq_a = ma_s1 * ma_s1;
	assign sq_b = mb_s1 * mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		na_s1 <= a_in[W-1];
		nb_s1 <= b_in[W-1];
		ma_s1 <= a_in[W-1] ? (~a_in + 1'b1) : a_in;
		mb_s1 <= b_in[W-1] ? (~b_in + 1'b1) : b_in;
		pa_s2 <= sq_a;
		pb_s2 <= sq_b;
		na_s2 <= na_s1;
		nb_s2 <= nb_s1;
		pa_s3 <= pa_s2;
		pb_s3 <= pb_s2;
		n_s3  <= pa_s2 + pb_s2;
		na_s3 <= na_s2;
		nb_s3 <= nb_s2;
	end

	// division lanes
	logic           dva_valid, dvb_valid;
	logic [2*W:0]   qa, qb;
	logic [2*W+1:0] dva_side;
	logic           dvb_side;

	gr_divider #(.W(W), .SIDE_W(2*W+2)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.num      (pa_s3),
		.den      (n_s3),
		.side_in  ({n_s3, na_s3, n_s3 == '0}),
		.out_valid(dva_valid),
		.quo      (qa),
		.side_out (dva_side)
	);

	gr_divider #(.W(W), .SIDE_W(1)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.num      (pb_s3),
		.den      (n_s3),
		.side_in  (nb_s3),
		.out_valid(dvb_valid),
		.quo      (qb),
		.side_out (dvb_side)
	);

	// root lanes
	logic         sqa_valid, sqb_valid, sqr_valid;
	logic [W:0]   ta, tb, tr;
	logic         na_d, nb_d, zero_d;

	gr_isqrt #(.IN_W(2*W+2), .SIDE_W(1)) u_sqrt_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dva_valid),
		.rad      ({1'b0, qa}),
		.side_in  (dva_side[1]),
		.out_valid(sqa_valid),
		.root     (ta),
		.side_out (na_d)
	);

	gr_isqrt #(.IN_W(2*W+2), .SIDE_W(1)) u_sqrt_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dvb_valid),
		.rad      ({1'b0, qb}),
		.side_in  (dvb_side),
		.out_valid(sqb_valid),
		.root     (tb),
		.side_out (nb_d)
	);

	gr_isqrt #(.IN_W(2*W+2), .SIDE_W(1)) u_sqrt_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dva_valid),
		.rad      ({dva_side[2*W+1:2], 2'b00}),
		.side_in  (dva_side[0]),
		.out_valid(sqr_valid),
		.root     (tr),
		.side_out (zero_d)
	);

	// output stage
	logic         done_q;
	logic [W-1:0] cos_q, sin_q, radius_q;
	logic [W+1:0] r_sum;

	assign r_sum = {1'b0, tr} + {{(W+1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sqa_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (zero_d) begin
			cos_q    <= {1'b0, {(W-1){1'b1}}};
			sin_q    <= '0;
			radius_q <= '0;
		end else begin
			cos_q    <= to_field(ta, na_d);
			sin_q    <= to_field(tb, nb_d);
			radius_q <= r_sum[W:1];
		end
	end

	assign done       = done_q;
	assign cos_out    = $signed(cos_q);
	assign sin_out    = $signed(sin_q);
	assign radius_out = radius_q;

	`GR_ASSERT_NOW(a_lanes_div, 1'b1, dva_valid == dvb_valid, "divider lanes out of step")
	`GR_ASSERT_NOW(a_lanes_sqrt, sqa_valid, sqb_valid && sqr_valid, "root lanes out of step")
	`GR_ASSERT_NEXT(a_done_follows, sqa_valid, done, "lost result word")
	`GR_ASSERT_NEXT(a_no_extra, !sqa_valid, !done, "spurious result word")
	`GR_ASSERT_NOW(a_zero_radius, done && radius_out == '0, sin_out == '0, "zero radius with nonzero sine")
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Givens rotation unit: directed corner pairs and
// random pairs with random start gaps, each rotation word checked against an
// integer-exact model of c, s and r.
// ----------------------------------------------------------------------------
module tb;
	import gr_pkg::*;

	localparam int W = GR_DATA_WIDTH;
	localparam int F = W - 1;
	localparam int LATENCY = 3 * W + 6;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [W-1:0] cos_v;
		logic signed [W-1:0] sin_v;
		logic [W-1:0] radius_v;
	} rotation_t;

	// largest q in [0, 2^F] with (2q-1)^2 * n <= (m * 2^(F+1))^2
	function automatic longint unsigned unit_ratio(longint unsigned m, longint unsigned n);
		longint unsigned lo, hi, mid, odd;
		logic [127:0] rhs, lhs;
		lo = 0;
		hi = 1 << F;
		rhs = (128'(m) << (F + 1)) * (128'(m) << (F + 1));
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			lhs = 128'(odd) * 128'(odd) * 128'(n);
			if (lhs <= rhs) lo = mid; else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint unsigned nearest_root(longint unsigned n);
		longint unsigned lo, hi, mid, odd;
		lo = 0;
		hi = 1 << W;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			if (odd * odd <= 4 * n) lo = mid; else hi = mid - 1;
		end
		return lo;
	endfunction

	// saturate +1.0, keep -1.0 exact
	function automatic logic signed [W-1:0] scale_sign(longint unsigned q, bit neg);
		if (neg) return W'(-longint'(q));
		if (q > (1 << F) - 1) q = (1 << F) - 1;
		return W'(q);
	endfunction

	// exact rotation of (a, b), rounding half away from zero
	function automatic rotation_t rotate_pair(logic signed [W-1:0] a, logic signed [W-1:0] b);
		rotation_t res;
		longint unsigned ma, mb, n;
		// widen before negating so the most negative value keeps its magnitude
		ma = (a < 0) ? -longint'(a) : longint'(a);
		mb = (b < 0) ? -longint'(b) : longint'(b);
		n = ma * ma + mb * mb;
		if (n == 0) begin
			res.cos_v = W'((1 << F) - 1);
			res.sin_v = '0;
			res.radius_v = '0;
			return res;
		end
		res.cos_v = scale_sign(unit_ratio(ma, n), a < 0);
		res.sin_v = scale_sign(unit_ratio(mb, n), b < 0);
		res.radius_v = W'(nearest_root(n));
		return res;
	endfunction

	class rotation_board;
		rotation_t pending[$];
		int errors;

		function void note_pair(logic signed [W-1:0] a, logic signed [W-1:0] b);
			pending.push_back(rotate_pair(a, b));
		endfunction

		function void check_word(rotation_t got);
			rotation_t want;
			if (pending.size() == 0) begin
				$error("unexpected rotation word");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.cos_v !== want.cos_v) begin
				$error("cos_out expected %0d got %0d", want.cos_v, got.cos_v);
				errors++;
			end
			if (got.sin_v !== want.sin_v) begin
				$error("sin_out expected %0d got %0d", want.sin_v, got.sin_v);
				errors++;
			end
			if (got.radius_v !== want.radius_v) begin
				$error("radius_out expected %0d got %0d", want.radius_v, got.radius_v);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic signed [W-1:0] a_in, b_in, cos_out, sin_out;
	logic [W-1:0] radius_out;
	longint cycles;
	rotation_board board;

	givens_rotation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_in(a_in), .b_in(b_in), .done(done),
		.cos_out(cos_out), .sin_out(sin_out), .radius_out(radius_out)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		board = new();
		cycles = 0;
		arst_n = 0;
		start = 0;
		a_in = 0;
		b_in = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sample results and accepted words at each edge
	always @(posedge clk) begin
		rotation_t got;
		if (arst_n) begin
			if (start && !busy) board.note_pair(a_in, b_in);
			if (done) begin
				got.cos_v = cos_out;
				got.sin_v = sin_out;
				got.radius_v = radius_out;
				board.check_word(got);
			end
		end
	end

	// present one word and hold it until accepted
	task automatic send_pair(logic signed [W-1:0] a, logic signed [W-1:0] b);
		start <= 1;
		a_in <= a;
		b_in <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// drop start for a random gap, mostly none or short
	task automatic idle_gap();
		int n, r;
		r = $urandom_range(0, 99);
		if (r < 55) n = 0;
		else if (r < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(4, 40);
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return W'($urandom_range(0, 3)) - 16'sd1 - 16'sd1;
			1: return W'($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
			2: return W'($urandom_range(0, 15)) - 16'sd8;
			default: return W'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [W-1:0] corners[7];
		int wait_cnt;
		corners = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7ffe, 16'sh7fff};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// corner pairs: both zero, single-axis cases, extremes
		foreach (corners[i]) begin
			send_pair(corners[i], 16'sd0);
			send_pair(16'sd0, corners[i]);
		end
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7fff, 16'sh7fff);
		send_pair(16'sh7fff, 16'sh8000);
		send_pair(16'sh8000, 16'sh7fff);
		send_pair(16'sd3, 16'sd4);
		send_pair(-16'sd3, -16'sd4);
		for (int k = 0; k < 1800; k++) begin
			idle_gap();
			send_pair(pick_value(), pick_value());
		end
		start <= 0;
		wait_cnt = 0;
		while (board.pending.size() != 0 && wait_cnt < 20 * LATENCY) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
